@@ src/vrld_pkg.sv @@
// ----------------------------------------------------------------------------
// vrld_pkg: shared constants and types for the vote/RLE line decoder
// Sizes, symbol codes, error codes and the beat structs between the
// sequencer and the history store.
// ----------------------------------------------------------------------------
package vrld_pkg;

  // Storage sizes
  localparam int unsigned HIST_DEPTH   = 1024;
  localparam int unsigned MAX_LINES    = 256;
  localparam int unsigned MAX_LINE_LEN = 64;
  localparam int unsigned MAX_RUN      = 28;

  localparam int unsigned HIST_AW = $clog2(HIST_DEPTH);
  localparam int unsigned FILL_W  = HIST_AW + 1;
  localparam int unsigned LS_AW   = $clog2(MAX_LINES);
  localparam int unsigned LT_W    = LS_AW;
  localparam int unsigned CNT_W   =
    $clog2(((MAX_LINE_LEN > MAX_RUN) ? MAX_LINE_LEN : MAX_RUN) + 1);

  localparam logic [FILL_W-1:0] FILL_FULL    = FILL_W'(HIST_DEPTH);
  localparam logic [LT_W-1:0]   LT_LIMIT     = LT_W'(MAX_LINES - 1);
  localparam logic [FILL_W-1:0] LINE_LEN_CAP = FILL_W'(MAX_LINE_LEN);
  localparam logic [CNT_W-1:0]  COPY_CAP     = CNT_W'(MAX_LINE_LEN);

  // Symbol codes
  localparam logic [7:0] CH_ZERO    = 8'd0;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CH_EQ      = 8'd61;
  localparam logic [7:0] CH_UP_A    = 8'd65;
  localparam logic [7:0] CH_UP_Z    = 8'd90;
  localparam logic [7:0] CH_LO_A    = 8'd97;
  localparam logic [7:0] CH_LO_Z    = 8'd122;
  localparam logic [7:0] DIG_LO     = 8'd38;   // '0' - 10
  localparam logic [7:0] DIG_HI     = 8'd47;   // '9' - 10
  localparam logic [7:0] DDIG_LO    = 8'd28;   // '0' - 20
  localparam logic [7:0] DDIG_HI    = 8'd37;   // '9' - 20
  localparam logic [7:0] DIG_OFS    = 8'd10;
  localparam logic [7:0] DDIG_OFS   = 8'd20;
  localparam logic [7:0] CASE_OFS   = 8'd32;
  localparam logic [7:0] CNT_LO     = 8'd3;
  localparam logic [7:0] CNT_HI     = 8'd28;
  localparam logic [7:0] CNT_TEN    = 8'd126;  // stands for a count of ten
  localparam logic [CNT_W-1:0] RUN_TEN = CNT_W'(10);

  typedef enum logic [2:0] {
    ERR_OK   = 3'd0,
    ERR_VOTE = 3'd1,
    ERR_CODE = 3'd2,
    ERR_LINE = 3'd3,
    ERR_OVF  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    PK_NONE   = 2'd0,
    PK_DIGIT  = 2'd1,
    PK_LETTER = 2'd2,
    PK_LINE   = 2'd3
  } pend_e;

  // One output byte going through the store, plus a state clear
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    err_e       err;
    logic       store;
    logic       clear;
  } put_req_t;

  typedef struct packed {
    logic [LS_AW-1:0]   ls_addr;
    logic [HIST_AW-1:0] hist_addr;
  } rd_req_t;

  typedef struct packed {
    logic [FILL_W-1:0] ls_data;
    logic [7:0]        hist_data;
    logic [LT_W-1:0]   line_total;
    err_e              err;
  } store_rsp_t;

  function automatic logic is_count(input logic [7:0] v);
    return ((v >= CNT_LO) && (v <= CNT_HI) && (v != CH_NL)) || (v == CNT_TEN);
  endfunction

endpackage

@@ src/vrld_vote.sv @@
// ----------------------------------------------------------------------------
// vrld_vote: two-of-three symbol voter
// Picks the majority copy; three different copies give a caret and a flag.
// ----------------------------------------------------------------------------
module vrld_vote (
  input  logic [7:0] copy_a_i,
  input  logic [7:0] copy_b_i,
  input  logic [7:0] copy_c_i,
  output logic [7:0] sym_o,
  output logic       mismatch_o
);

  always_comb begin
    mismatch_o = 1'b0;
    if ((copy_a_i == copy_b_i) || (copy_a_i == copy_c_i)) begin
      sym_o = copy_a_i;
    end else if (copy_b_i == copy_c_i) begin
      sym_o = copy_b_i;
    end else begin
      sym_o      = vrld_pkg::CH_CARET;
      mismatch_o = 1'b1;
    end
  end

endmodule

@@ src/vrld_store.sv @@
// ----------------------------------------------------------------------------
// vrld_store: text history and line-start table
// Two synchronous RAMs (registered read), fill and line counters, and the
// overflow flagging applied to every stored byte.
// ----------------------------------------------------------------------------
module vrld_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vrld_pkg::put_req_t   put_i,
  input  vrld_pkg::rd_req_t    rd_i,
  output vrld_pkg::store_rsp_t rsp_o
);

  logic [7:0]                    hist_mem [vrld_pkg::HIST_DEPTH];
  logic [vrld_pkg::FILL_W-1:0]   ls_mem   [vrld_pkg::MAX_LINES];

  logic [vrld_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [vrld_pkg::LT_W-1:0]     lt_q, lt_d;
  logic [7:0]                    hist_rdata_q;
  logic [vrld_pkg::FILL_W-1:0]   ls_rdata_q;

  logic                          full, is_nl, lt_room, wr_hist, wr_ls;
  logic [vrld_pkg::LS_AW-1:0]    ls_waddr;
  logic [vrld_pkg::FILL_W-1:0]   ls_wdata;
  vrld_pkg::err_e                err;

  always_comb begin
    full     = (fill_q == vrld_pkg::FILL_FULL);
    is_nl    = (put_i.ch == vrld_pkg::CH_NL);
    lt_room  = (lt_q < vrld_pkg::LT_LIMIT);
    wr_hist  = put_i.valid && put_i.store && !full;
    wr_ls    = wr_hist && is_nl && lt_room;
    ls_waddr = vrld_pkg::LS_AW'(lt_q + 1'b1);
    ls_wdata = fill_q + 1'b1;

    err = put_i.err;
    if (put_i.store && (put_i.err == vrld_pkg::ERR_OK) && (full || (is_nl && !lt_room))) begin
      err = vrld_pkg::ERR_OVF;
    end

    fill_d = fill_q;
    lt_d   = lt_q;
    if (wr_hist) begin
      fill_d = fill_q + 1'b1;
    end
    if (wr_ls) begin
      lt_d = lt_q + 1'b1;
    end
    if (put_i.clear) begin
      fill_d = '0;
      lt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      lt_q   <= '0;
    end else begin
      fill_q <= fill_d;
      lt_q   <= lt_d;
    end
  end

  // Copy reads always sit below the fill point, writes at it: no overlap.
  always_ff @(posedge clk_i) begin
    if (wr_hist) begin
      hist_mem[fill_q[vrld_pkg::HIST_AW-1:0]] <= put_i.ch;
    end
    hist_rdata_q <= hist_mem[rd_i.hist_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_ls) begin
      ls_mem[ls_waddr] <= ls_wdata;
    end
    ls_rdata_q <= ls_mem[rd_i.ls_addr];
  end

  assign rsp_o.ls_data    = ls_rdata_q;
  assign rsp_o.hist_data  = hist_rdata_q;
  assign rsp_o.line_total = lt_q;
  assign rsp_o.err        = err;

endmodule

@@ src/vrld_seq.sv @@
// ----------------------------------------------------------------------------
// vrld_seq: decode sequencer and output register
// Decodes one voted symbol into a flush run and a main run or a line copy,
// then plays them out one byte per beat through the store.
// ----------------------------------------------------------------------------
module vrld_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           sym_i,
  input  logic                 mismatch_i,
  input  logic                 end_marker_i,
  input  vrld_pkg::store_rsp_t rsp_i,
  output vrld_pkg::put_req_t   put_o,
  output vrld_pkg::rd_req_t    rd_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic [2:0]           error_code_o,
  output logic                 run_last_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PRE    = 6'b000010,
    S_MAIN   = 6'b000100,
    S_LINE_A = 6'b001000,
    S_LINE_B = 6'b010000,
    S_COPY   = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  vrld_pkg::pend_e               pk_q, pk_d;
  logic [7:0]                    ps_q, ps_d;
  logic [1:0]                    pre_cnt_q, pre_cnt_d;
  logic [7:0]                    pre_ch_q, pre_ch_d;
  vrld_pkg::err_e                pre_err_q, pre_err_d;
  logic                          pre_store_q, pre_store_d;
  logic [vrld_pkg::CNT_W-1:0]    main_cnt_q, main_cnt_d;
  logic [7:0]                    main_ch_q, main_ch_d;
  vrld_pkg::err_e                main_err_q, main_err_d;
  logic                          main_store_q, main_store_d;
  logic                          clr_q, clr_d;
  logic [vrld_pkg::LS_AW-1:0]    n_q, n_d;
  logic [vrld_pkg::FILL_W-1:0]   e_q, e_d;
  logic                          trunc_q, trunc_d;
  logic [vrld_pkg::HIST_AW-1:0]  ptr_q, ptr_d;

  logic                          out_valid_q;
  logic [7:0]                    out_char_q;
  logic [2:0]                    out_err_q;
  logic                          out_last_q;

  logic                          emit_ok, out_load, out_last, copy;
  logic [7:0]                    pch;
  logic [1:0]                    flush_cnt;
  logic [vrld_pkg::FILL_W-1:0]   line_s, line_len;

  always_comb begin
    emit_ok = !out_valid_q || !out_stall_i;
    pch = (pk_q == vrld_pkg::PK_DIGIT) ? (ps_q + vrld_pkg::DIG_OFS) : (ps_q - vrld_pkg::CASE_OFS);
    case (pk_q)
      vrld_pkg::PK_DIGIT:  flush_cnt = 2'd1;
      vrld_pkg::PK_LETTER: flush_cnt = 2'd2;
      vrld_pkg::PK_LINE:   flush_cnt = 2'd1;
      default:             flush_cnt = 2'd0;
    endcase

    state_d      = state_q;
    pk_d         = pk_q;
    ps_d         = ps_q;
    pre_cnt_d    = pre_cnt_q;
    pre_ch_d     = pre_ch_q;
    pre_err_d    = pre_err_q;
    pre_store_d  = pre_store_q;
    main_cnt_d   = main_cnt_q;
    main_ch_d    = main_ch_q;
    main_err_d   = main_err_q;
    main_store_d = main_store_q;
    clr_d        = clr_q;
    n_d          = n_q;
    e_d          = e_q;
    trunc_d      = trunc_q;
    ptr_d        = ptr_q;
    copy         = 1'b0;
    line_s       = '0;
    line_len     = '0;

    put_o.valid = 1'b0;
    put_o.ch    = main_ch_q;
    put_o.err   = vrld_pkg::ERR_OK;
    put_o.store = 1'b0;
    put_o.clear = 1'b0;
    out_load    = 1'b0;
    out_last    = 1'b0;
    rd_o.ls_addr = sym_i[vrld_pkg::LS_AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pre_cnt_d    = 2'd0;
          pre_ch_d     = pch;
          pre_err_d    = vrld_pkg::ERR_OK;
          pre_store_d  = 1'b1;
          main_cnt_d   = '0;
          main_ch_d    = sym_i;
          main_err_d   = vrld_pkg::ERR_OK;
          main_store_d = 1'b1;
          clr_d        = 1'b0;
          n_d          = sym_i[vrld_pkg::LS_AW-1:0];
          pk_d         = vrld_pkg::PK_NONE;
          ps_d         = '0;
          if (end_marker_i) begin
            pre_cnt_d = flush_cnt;
            if (pk_q == vrld_pkg::PK_LINE) begin
              pre_ch_d    = vrld_pkg::CH_ZERO;
              pre_err_d   = vrld_pkg::ERR_LINE;
              pre_store_d = 1'b0;
            end
            clr_d = 1'b1;
          end else if (pk_q == vrld_pkg::PK_LINE) begin
            if (mismatch_i) begin
              main_cnt_d   = vrld_pkg::CNT_W'(1);
              main_ch_d    = vrld_pkg::CH_CARET;
              main_err_d   = vrld_pkg::ERR_VOTE;
              main_store_d = 1'b0;
            end else if ((sym_i == vrld_pkg::CH_ZERO) ||
                         (int'(sym_i) > int'(rsp_i.line_total))) begin
              main_cnt_d   = vrld_pkg::CNT_W'(1);
              main_ch_d    = vrld_pkg::CH_ZERO;
              main_err_d   = vrld_pkg::ERR_LINE;
              main_store_d = 1'b0;
            end else begin
              copy = 1'b1;
            end
          end else if ((pk_q != vrld_pkg::PK_NONE) && !mismatch_i &&
                       vrld_pkg::is_count(sym_i)) begin
            main_ch_d  = pch;
            main_cnt_d = (sym_i == vrld_pkg::CNT_TEN) ? vrld_pkg::RUN_TEN
                                                      : vrld_pkg::CNT_W'(sym_i);
          end else begin
            pre_cnt_d = flush_cnt;
            if (sym_i == vrld_pkg::CH_ZERO) begin
              clr_d = 1'b1;
            end else if (((sym_i >= vrld_pkg::CH_UP_A) && (sym_i <= vrld_pkg::CH_UP_Z)) ||
                         (sym_i == vrld_pkg::CH_NL)) begin
              main_cnt_d = vrld_pkg::CNT_W'(1);
            end else if ((sym_i >= vrld_pkg::DIG_LO) && (sym_i <= vrld_pkg::DIG_HI)) begin
              pk_d = vrld_pkg::PK_DIGIT;
              ps_d = sym_i;
            end else if ((sym_i >= vrld_pkg::DDIG_LO) && (sym_i <= vrld_pkg::DDIG_HI)) begin
              main_ch_d  = sym_i + vrld_pkg::DDIG_OFS;
              main_cnt_d = vrld_pkg::CNT_W'(2);
            end else if ((sym_i >= vrld_pkg::CH_LO_A) && (sym_i <= vrld_pkg::CH_LO_Z)) begin
              pk_d = vrld_pkg::PK_LETTER;
              ps_d = sym_i;
            end else if (sym_i == vrld_pkg::CH_EQ) begin
              pk_d = vrld_pkg::PK_LINE;
              ps_d = sym_i;
            end else begin
              main_cnt_d   = vrld_pkg::CNT_W'(1);
              main_err_d   = mismatch_i ? vrld_pkg::ERR_VOTE : vrld_pkg::ERR_CODE;
              main_store_d = 1'b0;
            end
          end

          if (pre_cnt_d != 2'd0) begin
            state_d = S_PRE;
          end else if (copy) begin
            state_d = S_LINE_A;
          end else if (main_cnt_d != '0) begin
            state_d = S_MAIN;
          end else begin
            put_o.clear = clr_d;   // nothing to emit: clear right away
          end
        end
      end

      S_PRE: begin
        if (emit_ok) begin
          put_o.valid = 1'b1;
          put_o.ch    = pre_ch_q;
          put_o.err   = pre_err_q;
          put_o.store = pre_store_q;
          out_load    = 1'b1;
          out_last    = (pre_cnt_q == 2'd1) && (main_cnt_q == '0);
          pre_cnt_d   = pre_cnt_q - 1'b1;
          if (pre_cnt_q == 2'd1) begin
            if (main_cnt_q != '0) begin
              state_d = S_MAIN;
            end else begin
              state_d     = S_IDLE;
              put_o.clear = clr_q;
            end
          end
        end
      end

      S_MAIN: begin
        if (emit_ok) begin
          put_o.valid = 1'b1;
          put_o.ch    = main_ch_q;
          put_o.err   = main_err_q;
          put_o.store = main_store_q;
          out_load    = 1'b1;
          out_last    = (main_cnt_q == vrld_pkg::CNT_W'(1));
          main_cnt_d  = main_cnt_q - 1'b1;
          if (out_last) begin
            state_d     = S_IDLE;
            put_o.clear = clr_q;
          end
        end
      end

      S_LINE_A: begin
        // ls[n] is in; fetch the start of line n from ls[n-1]
        e_d          = rsp_i.ls_data - 1'b1;
        rd_o.ls_addr = n_q - 1'b1;
        state_d      = S_LINE_B;
      end

      S_LINE_B: begin
        line_s     = (n_q == vrld_pkg::LS_AW'(1)) ? '0 : rsp_i.ls_data;
        line_len   = e_q - line_s;
        trunc_d    = (line_len > vrld_pkg::LINE_LEN_CAP);
        main_cnt_d = trunc_d ? vrld_pkg::COPY_CAP : line_len[vrld_pkg::CNT_W-1:0];
        ptr_d      = line_s[vrld_pkg::HIST_AW-1:0];
        state_d    = (line_len == '0) ? S_IDLE : S_COPY;
      end

      S_COPY: begin
        if (emit_ok) begin
          put_o.valid = 1'b1;
          put_o.ch    = rsp_i.hist_data;
          put_o.err   = (trunc_q && (main_cnt_q == vrld_pkg::CNT_W'(1))) ? vrld_pkg::ERR_OVF
                                                                       : vrld_pkg::ERR_OK;
          put_o.store = 1'b1;
          out_load    = 1'b1;
          out_last    = (main_cnt_q == vrld_pkg::CNT_W'(1));
          main_cnt_d  = main_cnt_q - 1'b1;
          ptr_d       = ptr_q + 1'b1;
          if (out_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_o.hist_addr = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pk_q        <= vrld_pkg::PK_NONE;
      ps_q        <= '0;
      pre_cnt_q   <= '0;
      main_cnt_q  <= '0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pk_q       <= pk_d;
      ps_q       <= ps_d;
      pre_cnt_q  <= pre_cnt_d;
      main_cnt_q <= main_cnt_d;
      clr_q      <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pre_ch_q     <= pre_ch_d;
    pre_err_q    <= pre_err_d;
    pre_store_q  <= pre_store_d;
    main_ch_q    <= main_ch_d;
    main_err_q   <= main_err_d;
    main_store_q <= main_store_d;
    n_q          <= n_d;
    e_q          <= e_d;
    trunc_q      <= trunc_d;
    ptr_q        <= ptr_d;
    if (out_load) begin
      out_char_q <= put_o.ch;
      out_err_q  <= rsp_i.err;
      out_last_q <= out_last;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign error_code_o = out_err_q;
  assign run_last_o   = out_last_q;

endmodule

@@ src/vote_rle_line_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// vote_rle_line_decoder_unit: triple-vote run-length and line-copy decoder
// Votes each symbol two-of-three, expands digit and letter runs, copies
// earlier text lines from a history RAM and flags errors per byte.
// ----------------------------------------------------------------------------
// Results: every result leaves through the output register; a line copy
//   first reads the line table twice (end, then start of the line).
// Flow: no new input beat until every result of the last is loaded; the
//   output register emits at most one result per cycle, held on out_stall_i.
// Reset: asynchronous, active low; clears decode state and counters. The
//   history and line-table RAMs are not cleared, no clearing pass is needed.
module vote_rle_line_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] copy_a_i,
  input  logic [7:0] copy_b_i,
  input  logic [7:0] copy_c_i,
  input  logic       end_marker_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic [2:0] error_code_o,
  output logic       run_last_o
);

  // Voted symbol; only looked at by the sequencer in the accept cycle
  logic [7:0]           sym;
  logic                 mismatch;

  // Sequencer <-> store: one put beat per emitted byte, RAM read addresses,
  // and the registered read data plus the final error for the put beat.
  vrld_pkg::put_req_t   put;
  vrld_pkg::rd_req_t    rd;
  vrld_pkg::store_rsp_t rsp;

  vrld_vote u_vote (
    .copy_a_i   (copy_a_i),
    .copy_b_i   (copy_b_i),
    .copy_c_i   (copy_c_i),
    .sym_o      (sym),
    .mismatch_o (mismatch)
  );

  // Sequencer: decode, flush/run/copy playback, output register
  vrld_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sym_i        (sym),
    .mismatch_i   (mismatch),
    .end_marker_i (end_marker_i),
    .rsp_i        (rsp),
    .put_o        (put),
    .rd_o         (rd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .error_code_o (error_code_o),
    .run_last_o   (run_last_o)
  );

  // History RAM, line-start RAM, fill and line counters
  vrld_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .put_i  (put),
    .rd_i   (rd),
    .rsp_o  (rsp)
  );

  // A non-final result leaving means the item is still being played out.
  a_busy_until_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !run_last_o) |-> in_stall_o)
    else $error("block idle before last result of an item");

  // Bad line number results carry a zero byte.
  a_bad_line_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o == vrld_pkg::ERR_LINE)) |-> (out_char_o == 8'd0))
    else $error("bad line result with nonzero byte");

  // Busy only ever starts right after an input beat.
  a_busy_after_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("sequencer left idle without an input beat");

endmodule
